>>> rtl/rhtfm_pkg.sv
// Shared types, constants and helpers for the rectangle hit test focus map.
// Used by the top level and the testbench; depends on nothing else.

package rhtfm_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int HIT_INDEX_W = 6;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 64;

  localparam logic [15:0] FORCE_ARROW = 16'hFFFF;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_HAND = 2'd0;
  localparam logic [1:0] REG_TEXT = 2'd1;
  localparam logic [1:0] REG_FWD  = 2'd2;

  typedef enum logic [2:0] {
    ACT_BEGIN  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_END    = 3'd2,
    ACT_QUERY  = 3'd3,
    ACT_CLICK  = 3'd4,
    ACT_DEACT  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    SHAPE_ARROW = 2'd0,
    SHAPE_HAND  = 2'd1,
    SHAPE_TEXT  = 2'd2
  } shape_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  etype;
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } entry_t;

  // Types above 63 belong to no class.
  function automatic logic in_class(input logic [63:0] mask, input logic [7:0] etype);
    logic r;
    r = (etype[7:6] == 2'b00) && mask[etype[5:0]];
    return r;
  endfunction

endpackage

>>> rtl/rhtfm_if.sv
// Valid/ready channel interfaces for the command and result words.
// Field widths match rhtfm_pkg but are written out; no dependencies.

interface rhtfm_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] elem_id;
  logic [15:0] elem_w;
  logic [15:0] elem_h;
  logic [7:0]  elem_type;
  logic [7:0]  buttons;

  modport source (
    output valid, action, pos_x, pos_y, elem_id, elem_w, elem_h, elem_type, buttons,
    input  ready
  );
  modport sink (
    input  valid, action, pos_x, pos_y, elem_id, elem_w, elem_h, elem_type, buttons,
    output ready
  );
endinterface

interface rhtfm_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [5:0]  hit_index;
  logic [15:0] hit_id;
  logic [7:0]  hit_type;
  logic [1:0]  cursor_shape;
  logic        cursor_changed;
  logic        forwarding;
  logic [15:0] forward_id;
  logic        click_sent;
  logic [15:0] click_x;
  logic [15:0] click_y;
  logic [7:0]  click_buttons;

  modport source (
    output valid, hit, hit_index, hit_id, hit_type, cursor_shape, cursor_changed,
           forwarding, forward_id, click_sent, click_x, click_y, click_buttons,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_index, hit_id, hit_type, cursor_shape, cursor_changed,
           forwarding, forward_id, click_sent, click_x, click_y, click_buttons,
    output ready
  );
endinterface

>>> rtl/rhtfm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; width and depth are set by the instantiating module.

module rhtfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rectangle_hit_test_focus_map.sv
// Top level of the rectangle hit test focus map: control, scan and result register.
// Depends on rhtfm_pkg, the channel interfaces in rhtfm_if and the RAM rhtfm_ram.
//
// Usage. Command words arrive on the cmd channel and each produces exactly one
// result word on the res channel; both use valid/ready and a word moves at a
// rising edge where both are high. The three class masks are written over the
// APB port at byte addresses 0, 8 and 16 (64-bit data, pready tied high) and
// should only be changed while the block is idle.
// The table of rectangles lives in a single synchronous RAM, one entry per
// word. Begin, append, deactivate, unused codes, forced-arrow queries and an
// end map while not forwarding finish without a scan: they go from idle
// straight to the final state, which loads the result and returns to idle.
// A cursor query, a click, or an end map while forwarding walks the table from
// index 0 through the one read port, one entry per cycle, and stops at the
// first match or after the last entry, then passes to the final state, which
// loads the result and returns to idle. The single RAM read port sets the pace.
// The block takes one command at a time. A finished result sits in the output
// register while the next command is accepted and worked on; if the receiver
// stalls, the next result waits in the final state until the register frees.
// Reset (synchronous, active high) empties the table count, leaves forwarding,
// clears the focused id, sets the arrow cursor and zeroes the masks. The table
// memory itself is not cleared: only appended entries are ever read.

module rectangle_hit_test_focus_map
  import rhtfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  rhtfm_cmd_if.sink             cmd,
  rhtfm_res_if.source           res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  hit_index;
    logic [15:0] hit_id;
    logic [7:0]  hit_type;
    logic [1:0]  cursor_shape;
    logic        cursor_changed;
    logic        forwarding;
    logic [15:0] forward_id;
    logic        click_sent;
    logic [15:0] click_x;
    logic [15:0] click_y;
    logic [7:0]  click_buttons;
  } result_t;

  state_t state;

  // Configuration registers.
  logic [63:0] hand_mask;
  logic [63:0] text_mask;
  logic [63:0] fwd_mask;

  // Command fields kept for the length of the item.
  logic [2:0]  act;
  logic [15:0] px;
  logic [15:0] py;
  logic [7:0]  btn;

  // Persistent block state.
  logic [CNT_W-1:0] entry_count;
  logic             forward_active;
  logic [15:0]      focused_id;
  shape_t           previous_shape;

  // Scan pipeline.
  logic [CNT_W-1:0] issue_idx;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  logic [15:0]      hit_id;
  logic [7:0]       hit_type;

  // Output register.
  logic    out_valid;
  result_t out_word;

  logic             cmd_fire;
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             table_full;
  logic             needs_scan;
  logic             match_now;
  logic             contains;
  logic [16:0]      x_end;
  logic [16:0]      y_end;
  logic             fin_fire;
  logic             cfg_write;

  shape_t      shape_next;
  logic        forward_active_next;
  logic [15:0] focused_id_next;
  result_t     out_word_next;

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hand_mask <= '0;
      text_mask <= '0;
      fwd_mask  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        REG_HAND: hand_mask <= pwdata;
        REG_TEXT: text_mask <= pwdata;
        REG_FWD:  fwd_mask  <= pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_HAND: prdata = hand_mask;
      REG_TEXT: prdata = text_mask;
      REG_FWD:  prdata = fwd_mask;
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Table memory: appends write at acceptance unless full, scans read one entry a cycle.
  // ---------------------------------------------------------------------------
  assign cmd.ready  = (state == S_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign table_full = (entry_count == CNT_W'(MAX_ENTRIES));
  assign ram_we     = cmd_fire && (cmd.action == ACT_APPEND) && !table_full;

  always_comb begin
    wr_entry.id    = cmd.elem_id;
    wr_entry.etype = cmd.elem_type;
    wr_entry.h     = cmd.elem_h;
    wr_entry.w     = cmd.elem_w;
    wr_entry.y     = cmd.pos_y;
    wr_entry.x     = cmd.pos_x;
  end

  // A new read is issued while entries remain and no match has been seen.
  assign ram_re    = (state == S_SCAN) && (issue_idx < entry_count) && !match_now;
  assign ram_raddr = issue_idx[IDX_W-1:0];

  rhtfm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  // Containment test with 17-bit edges so that x + w never wraps.
  assign x_end    = {1'b0, rd_entry.x} + {1'b0, rd_entry.w};
  assign y_end    = {1'b0, rd_entry.y} + {1'b0, rd_entry.h};
  assign contains = (px >= rd_entry.x) && ({1'b0, px} < x_end)
                 && (py >= rd_entry.y) && ({1'b0, py} < y_end);

  // End map looks for the focused id; queries and clicks look for the point.
  assign match_now = (state == S_SCAN) && rd_valid
                  && ((act == ACT_END) ? (rd_entry.id == focused_id) : contains);

  // Query with a forced-arrow coordinate skips the scan, as does an end map
  // while not forwarding.
  always_comb begin
    unique case (cmd.action)
      ACT_QUERY: needs_scan = (cmd.pos_x != FORCE_ARROW) && (cmd.pos_y != FORCE_ARROW);
      ACT_CLICK: needs_scan = 1'b1;
      ACT_END:   needs_scan = forward_active;
      default:   needs_scan = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State updates and the result word, settled when the item leaves.
  // ---------------------------------------------------------------------------
  assign fin_fire = (state == S_FIN) && (!out_valid || res.ready);

  always_comb begin
    shape_next          = previous_shape;
    forward_active_next = forward_active;
    focused_id_next     = focused_id;
    out_word_next       = '0;

    unique case (act)
      ACT_END: begin
        if (forward_active && !found) begin
          forward_active_next = 1'b0;
          focused_id_next     = '0;
        end
      end
      ACT_QUERY: begin
        if (!found) begin
          shape_next = SHAPE_ARROW;
        end else if (in_class(hand_mask, hit_type)) begin
          shape_next = SHAPE_HAND;
        end else if (in_class(text_mask, hit_type)) begin
          shape_next = SHAPE_TEXT;
        end else begin
          shape_next = SHAPE_ARROW;
        end
        out_word_next.cursor_changed = (shape_next != previous_shape);
      end
      ACT_CLICK: begin
        if (!found) begin
          forward_active_next = 1'b0;
          focused_id_next     = '0;
        end else if (in_class(fwd_mask, hit_type)) begin
          forward_active_next = 1'b1;
          focused_id_next     = hit_id;
        end
        out_word_next.click_sent    = 1'b1;
        out_word_next.click_x       = px;
        out_word_next.click_y       = py;
        out_word_next.click_buttons = btn;
      end
      ACT_DEACT: begin
        forward_active_next = 1'b0;
        focused_id_next     = '0;
      end
      default: ;
    endcase

    if (found && ((act == ACT_QUERY) || (act == ACT_CLICK))) begin
      out_word_next.hit       = 1'b1;
      out_word_next.hit_index = HIT_INDEX_W'(hit_idx);
      out_word_next.hit_id    = hit_id;
      out_word_next.hit_type  = hit_type;
    end
    out_word_next.cursor_shape = shape_next;
    out_word_next.forwarding   = forward_active_next;
    out_word_next.forward_id   = forward_active_next ? focused_id_next : 16'h0000;
  end

  // ---------------------------------------------------------------------------
  // Control sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entry_count    <= '0;
      forward_active <= 1'b0;
      focused_id     <= '0;
      previous_shape <= SHAPE_ARROW;
      rd_valid       <= 1'b0;
      found          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (res.ready && !fin_fire) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            found     <= 1'b0;
            rd_valid  <= 1'b0;
            issue_idx <= '0;
            if (cmd.action == ACT_BEGIN) begin
              entry_count <= '0;
            end
            if (ram_we) begin
              entry_count <= entry_count + 1'b1;
            end
            state <= needs_scan ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          rd_valid <= ram_re;
          if (ram_re) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (match_now) begin
            found <= 1'b1;
            state <= S_FIN;
          end else if (!ram_re && !rd_valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          rd_valid <= 1'b0;
          if (fin_fire) begin
            previous_shape <= shape_next;
            forward_active <= forward_active_next;
            focused_id     <= focused_id_next;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      act <= cmd.action;
      px  <= cmd.pos_x;
      py  <= cmd.pos_y;
      btn <= cmd.buttons;
    end
    if (ram_re) begin
      rd_idx <= ram_raddr;
    end
    if (match_now) begin
      hit_idx  <= rd_idx;
      hit_id   <= rd_entry.id;
      hit_type <= rd_entry.etype;
    end
    if (fin_fire) begin
      out_word <= out_word_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.hit            = out_word.hit;
  assign res.hit_index      = out_word.hit_index;
  assign res.hit_id         = out_word.hit_id;
  assign res.hit_type       = out_word.hit_type;
  assign res.cursor_shape   = out_word.cursor_shape;
  assign res.cursor_changed = out_word.cursor_changed;
  assign res.forwarding     = out_word.forwarding;
  assign res.forward_id     = out_word.forward_id;
  assign res.click_sent     = out_word.click_sent;
  assign res.click_x        = out_word.click_x;
  assign res.click_y        = out_word.click_y;
  assign res.click_buttons  = out_word.click_buttons;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("table count above capacity");

  a_read_in_table: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (ram_raddr < entry_count))
    else $error("scan read beyond appended entries");

  a_match_ends_scan: assert property (@(posedge clk) disable iff (rst)
    match_now |=> (state == S_FIN) && found)
    else $error("match did not close the scan");

  a_fwd_id_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.forwarding) |-> (res.forward_id == 16'h0000))
    else $error("forward id shown while not forwarding");

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> res.valid && $stable(out_word))
    else $error("stalled result word changed");

endmodule

>>> tb/tb_rectangle_hit_test_focus_map.sv
// Self-checking testbench for rectangle_hit_test_focus_map: directed rows, then map sessions.
// Depends on rhtfm_pkg, the channel interfaces in rhtfm_if and the block's top level.

module tb_rectangle_hit_test_focus_map;
  import rhtfm_pkg::*;

  // Action codes the block ignores; they still produce a word showing the state.
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int RESET_CYCLES    = 8;
  localparam int RESET_ROWS      = 5;      // directed rows run with the reset masks
  localparam int N_PHASES        = 5;
  localparam int WORDS_PER_PHASE = 320;
  localparam int LONG_HOLD       = 200;    // cycles the receiver refuses results once
  localparam int TAIL_CYCLES     = 2 * (MAX_ENTRIES + 3) + 10;
  localparam int CYCLE_LIMIT     = 1000000;

  // One command word, the order of fields as on the channel.
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] elem_id;
    logic [15:0] elem_w;
    logic [15:0] elem_h;
    logic [7:0]  elem_type;
    logic [7:0]  buttons;
  } cmd_word_t;

  // One result word.
  typedef struct packed {
    logic        hit;
    logic [5:0]  hit_index;
    logic [15:0] hit_id;
    logic [7:0]  hit_type;
    logic [1:0]  cursor_shape;
    logic        cursor_changed;
    logic        forwarding;
    logic [15:0] forward_id;
    logic        click_sent;
    logic [15:0] click_x;
    logic [15:0] click_y;
    logic [7:0]  click_buttons;
  } res_word_t;

  // A directed row: the command, and a hand-written result where one is given.
  typedef struct {
    cmd_word_t cmd;
    bit        typed;
    res_word_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rhtfm_cmd_if cmd_if ();
  rhtfm_res_if res_if ();

  rectangle_hit_test_focus_map uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the block's state: the rectangle table, focus and cursor.
  logic [15:0] map_ids   [MAX_ENTRIES];
  logic [15:0] map_x     [MAX_ENTRIES];
  logic [15:0] map_y     [MAX_ENTRIES];
  logic [15:0] map_w     [MAX_ENTRIES];
  logic [15:0] map_h     [MAX_ENTRIES];
  logic [7:0]  map_types [MAX_ENTRIES];
  int          map_count  = 0;
  logic        fwd_on     = 1'b0;
  logic [15:0] focus_id   = '0;
  shape_t      last_shape = SHAPE_ARROW;
  logic [63:0] hand_mask  = '0;
  logic [63:0] text_mask  = '0;
  logic [63:0] fwd_mask   = '0;

  res_word_t expected_words [$];
  dir_row_t  dir_rows [$];

  int words_sent     = 0;
  int words_checked  = 0;
  int mismatches     = 0;
  int hits_seen      = 0;
  int clicks_seen    = 0;
  int shape_changes  = 0;
  int settings_used  = 0;
  int cycle_count    = 0;
  int hold_asked     = 0;
  int hold_seen      = 0;
  int long_left      = 0;
  int stall_left     = 0;
  bit calm           = 1'b0;

  // ---------------------------------------------------------------------------
  // Clock, and a cycle counter that ends a run that goes past the cycle limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still awaited", cycle_count,
               expected_words.size());
      $display("tb_rectangle_hit_test_focus_map NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor. Types above 63 are outside every class, whatever the masks hold.
  // ---------------------------------------------------------------------------
  function automatic logic type_in_mask(input logic [63:0] mask, input logic [7:0] t);
    return (t < 8'd64) && mask[t[5:0]];
  endfunction

  // Index of the first entry whose rectangle holds the point, or -1. The right
  // and bottom edges are formed at 17 bits so that they never wrap.
  function automatic int first_hit(input logic [15:0] px, input logic [15:0] py);
    logic [16:0] right;
    logic [16:0] bottom;
    for (int i = 0; i < map_count; i++) begin
      right  = {1'b0, map_x[i]} + {1'b0, map_w[i]};
      bottom = {1'b0, map_y[i]} + {1'b0, map_h[i]};
      if (px >= map_x[i] && {1'b0, px} < right && py >= map_y[i] && {1'b0, py} < bottom)
        return i;
    end
    return -1;
  endfunction

  function automatic res_word_t hit_test_predict(input cmd_word_t c);
    res_word_t r;
    int        idx;
    logic      found;
    shape_t    shp;
    r   = '0;
    idx = -1;
    // A query at the forced-arrow coordinate does no hit test at all.
    if (c.action == ACT_CLICK ||
        (c.action == ACT_QUERY && c.pos_x != FORCE_ARROW && c.pos_y != FORCE_ARROW))
      idx = first_hit(c.pos_x, c.pos_y);
    if (idx >= 0) begin
      r.hit       = 1'b1;
      r.hit_index = idx[5:0];
      r.hit_id    = map_ids[idx];
      r.hit_type  = map_types[idx];
    end
    case (c.action)
      ACT_BEGIN: map_count = 0;
      ACT_APPEND: begin
        // A full table ignores further appends.
        if (map_count < MAX_ENTRIES) begin
          map_ids[map_count]   = c.elem_id;
          map_x[map_count]     = c.pos_x;
          map_y[map_count]     = c.pos_y;
          map_w[map_count]     = c.elem_w;
          map_h[map_count]     = c.elem_h;
          map_types[map_count] = c.elem_type;
          map_count++;
        end
      end
      ACT_END: begin
        if (fwd_on) begin
          found = 1'b0;
          for (int i = 0; i < map_count; i++)
            if (map_ids[i] == focus_id) found = 1'b1;
          if (!found) begin
            fwd_on   = 1'b0;
            focus_id = '0;
          end
        end
      end
      ACT_QUERY: begin
        shp = SHAPE_ARROW;
        if (idx >= 0) begin
          if (type_in_mask(hand_mask, r.hit_type)) shp = SHAPE_HAND;
          else if (type_in_mask(text_mask, r.hit_type)) shp = SHAPE_TEXT;
        end
        if (shp != last_shape) begin
          r.cursor_changed = 1'b1;
          last_shape       = shp;
        end
      end
      ACT_CLICK: begin
        if (idx < 0) begin
          fwd_on   = 1'b0;
          focus_id = '0;
        end else if (type_in_mask(fwd_mask, r.hit_type)) begin
          fwd_on   = 1'b1;
          focus_id = r.hit_id;
        end
        r.click_sent    = 1'b1;
        r.click_x       = c.pos_x;
        r.click_y       = c.pos_y;
        r.click_buttons = c.buttons;
      end
      ACT_DEACT: begin
        fwd_on   = 1'b0;
        focus_id = '0;
      end
      default: ;
    endcase
    r.cursor_shape = last_shape;
    r.forwarding   = fwd_on;
    r.forward_id   = fwd_on ? focus_id : 16'h0000;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Every input is driven with a nonblocking assignment at a
  // rising edge, and valid gets at most one assignment in any time step.
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input cmd_word_t w, input bit typed, input res_word_t want);
    res_word_t predicted;
    int        gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.action    <= w.action;
    cmd_if.pos_x     <= w.pos_x;
    cmd_if.pos_y     <= w.pos_y;
    cmd_if.elem_id   <= w.elem_id;
    cmd_if.elem_w    <= w.elem_w;
    cmd_if.elem_h    <= w.elem_h;
    cmd_if.elem_type <= w.elem_type;
    cmd_if.buttons   <= w.buttons;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    // The word went in at this edge; its result cannot come before the next one.
    predicted = hit_test_predict(w);
    expected_words.push_back(typed ? want : predicted);
    if (w.action <= ACT_DEACT) words_sent++;
  endtask

  // Stop offering words and wait for every awaited result to be taken.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic apb_write(input logic [1:0] reg_code, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_code, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (reg_code)
      REG_HAND: hand_mask = value;
      REG_TEXT: text_mask = value;
      REG_FWD:  fwd_mask  = value;
      default: ;
    endcase
  endtask

  task automatic write_masks(input logic [63:0] hand, input logic [63:0] text,
                             input logic [63:0] fwd);
    apb_write(REG_HAND, hand);
    apb_write(REG_TEXT, text);
    apb_write(REG_FWD, fwd);
    settings_used++;
  endtask

  function automatic cmd_word_t mk_cmd(input logic [2:0] act, input logic [15:0] x,
                                       input logic [15:0] y, input logic [15:0] id,
                                       input logic [15:0] w, input logic [15:0] h,
                                       input logic [7:0] t, input logic [7:0] b);
    cmd_word_t c;
    c = '{act, x, y, id, w, h, t, b};
    return c;
  endfunction

  function automatic cmd_word_t random_word(input logic [2:0] act);
    cmd_word_t    c;
    logic [127:0] raw;
    raw      = {$urandom, $urandom, $urandom, $urandom};
    c        = raw[$bits(cmd_word_t)-1:0];
    c.action = act;
    return c;
  endfunction

  // Mostly modest sizes, with empty and full-width rectangles now and then.
  function automatic logic [15:0] random_size();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 3000));
    endcase
  endfunction

  // A point that usually falls inside some entry of the current table, so that
  // hits reach deep into the table; otherwise anywhere, extremes included.
  task automatic pick_point(output logic [15:0] px, output logic [15:0] py);
    int j;
    int ex;
    int ey;
    px = 16'($urandom);
    py = 16'($urandom);
    if (map_count > 0 && $urandom_range(0, 3) != 0) begin
      j = $urandom_range(0, map_count - 1);
      if (map_w[j] != 0 && map_h[j] != 0) begin
        ex = int'(map_x[j]) + int'(map_w[j]) - 1;
        ey = int'(map_y[j]) + int'(map_h[j]) - 1;
        if (ex > 65535) ex = 65535;
        if (ey > 65535) ey = 65535;
        px = 16'($urandom_range(ex, int'(map_x[j])));
        py = 16'($urandom_range(ey, int'(map_y[j])));
      end
    end else if ($urandom_range(0, 7) == 0) begin
      px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      py = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side. ready idles in short bursts, and once refuses results for a
  // long stretch so that the block fills up and holds off the command channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (long_left > 0) begin
      res_if.ready <= 1'b0;
      long_left--;
    end else if (hold_seen != hold_asked) begin
      hold_seen    = hold_asked;
      long_left    = LONG_HOLD - 1;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left   = $urandom_range(0, 2);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  function automatic string fmt_res(input res_word_t r);
    return $sformatf({"hit=%0d idx=%0d id=%h type=%h shape=%0d chg=%0d fwd=%0d fid=%h ",
                      "click=%0d x=%h y=%h btn=%h"},
                     r.hit, r.hit_index, r.hit_id, r.hit_type, r.cursor_shape,
                     r.cursor_changed, r.forwarding, r.forward_id, r.click_sent,
                     r.click_x, r.click_y, r.click_buttons);
  endfunction

  // Each accepted result word is held against the oldest awaited one.
  always @(posedge clk) begin
    res_word_t got;
    res_word_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = '{res_if.hit, res_if.hit_index, res_if.hit_id, res_if.hit_type,
              res_if.cursor_shape, res_if.cursor_changed, res_if.forwarding,
              res_if.forward_id, res_if.click_sent, res_if.click_x, res_if.click_y,
              res_if.click_buttons};
      if (expected_words.size() == 0) begin
        if (mismatches < 10)
          $display("result word with nothing awaited: %s", fmt_res(got));
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("mismatch on result word %0d", words_checked);
            $display("  expected %s", fmt_res(want));
            $display("  actual   %s", fmt_res(got));
          end
          mismatches++;
        end
        if (got.hit) hits_seen++;
        if (got.click_sent) clicks_seen++;
        if (got.cursor_changed) shape_changes++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed rows, then random map sessions under
  // several mask settings, and finally a quiet tail before the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    cmd_word_t w;
    res_word_t r;
    int        n_appends;
    int        n_uses;
    int        phase_end;
    bit        fill_table;

    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cmd_if.valid     = 1'b0;
    cmd_if.action    = ACT_BEGIN;
    cmd_if.pos_x     = '0;
    cmd_if.pos_y     = '0;
    cmd_if.elem_id   = '0;
    cmd_if.elem_w    = '0;
    cmd_if.elem_h    = '0;
    cmd_if.elem_type = '0;
    cmd_if.buttons   = '0;

    // Rows straight after reset: empty table, all masks clear, so every result
    // is zero except for the click event that a click always asks for.
    r = '0;
    dir_rows.push_back('{mk_cmd(ACT_QUERY, 16'h0000, 16'h0000, 0, 0, 0, 0, 0), 1'b1, r});
    r.click_sent    = 1'b1;
    r.click_x       = 16'hFFFF;
    r.click_y       = 16'hFFFF;
    r.click_buttons = 8'hFF;
    dir_rows.push_back('{mk_cmd(ACT_CLICK, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 8'hFF), 1'b1, r});
    r = '0;
    dir_rows.push_back('{mk_cmd(ACT_END, 0, 0, 0, 0, 0, 0, 0), 1'b1, r});
    dir_rows.push_back('{mk_cmd(ACT_DEACT, 0, 0, 0, 0, 0, 0, 0), 1'b1, r});
    dir_rows.push_back('{mk_cmd(ACT_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 8'hFF, 8'hFF), 1'b1, r});

    // A small map with a text and forwarding entry first, an empty-width entry,
    // a hand-and-text entry (hand wins), one at the far corner, one of a type
    // above 63 and a catch-all last of all.
    dir_rows.push_back('{mk_cmd(ACT_BEGIN, 0, 0, 0, 0, 0, 0, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_APPEND, 10, 10, 16'h1111, 20, 20, 8'd1, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_APPEND, 0, 0, 16'h2222, 0, 500, 8'd0, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_APPEND, 5, 5, 16'h3333, 100, 100, 8'd0, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_APPEND, 16'hFFFF, 16'hFFFF, 16'h4444, 16'hFFFF,
                                16'hFFFF, 8'd63, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_APPEND, 300, 300, 16'h0000, 10, 10, 8'hFF, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_APPEND, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd64, 0),
                         1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_QUERY, 15, 15, 0, 0, 0, 0, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_QUERY, 5, 5, 0, 0, 0, 0, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_QUERY, 16'hFFFF, 5, 0, 0, 0, 0, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_QUERY, 302, 305, 0, 0, 0, 0, 0), 1'b0, r});
    // Clicks: enter forwarding, a hit on a non-forwarding type that keeps it, an end map
    // that still finds the focused id, and a click on the far-corner entry.
    dir_rows.push_back('{mk_cmd(ACT_CLICK, 15, 15, 0, 0, 0, 0, 8'h01), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_CLICK, 5, 5, 0, 0, 0, 0, 8'h80), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_END, 0, 0, 0, 0, 0, 0, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_CLICK, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 8'h55), 1'b0, r});
    // A new map without the focused id drops forwarding at its end.
    dir_rows.push_back('{mk_cmd(ACT_BEGIN, 0, 0, 0, 0, 0, 0, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_APPEND, 0, 0, 16'h5555, 10, 10, 8'd1, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_END, 0, 0, 0, 0, 0, 0, 0), 1'b0, r});
    dir_rows.push_back('{mk_cmd(ACT_CLICK, 5, 5, 0, 0, 0, 0, 8'hAA), 1'b0, r});
    // A click that misses leaves forwarding.
    dir_rows.push_back('{mk_cmd(ACT_CLICK, 60000, 60000, 0, 0, 0, 0, 8'h00), 1'b0, r});

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == RESET_ROWS) begin
        drain_results();
        write_masks(64'h8000_0000_0000_0001, 64'h0000_0000_0000_0003,
                    64'h8000_0000_0000_0002);
      end
      push_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part. Each phase starts idle with a fresh mask setting; each
    // session is mostly a well-formed map followed by queries and clicks, with
    // missing begins or ends and stray words mixed in. The first session of
    // every phase appends past the table's capacity.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: write_masks({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        1: write_masks('1, '1, '1);
        2: write_masks('0, '0, '0);
        3: begin
          r.hit_id = 16'($urandom);
          w = random_word(ACT_BEGIN);
          write_masks({w.pos_x, w.pos_y, w.elem_id, w.elem_w},
                      ~{w.pos_x, w.pos_y, w.elem_id, w.elem_w}, {$urandom, $urandom});
        end
        default: write_masks({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom});
      endcase
      // The last phase runs with no idling on either side.
      if (ph == N_PHASES - 1) calm = 1'b1;
      // Once, the receiver holds off for a long stretch while words keep coming.
      if (ph == 1) hold_asked++;
      phase_end  = words_sent + WORDS_PER_PHASE;
      fill_table = 1'b1;
      while (words_sent < phase_end) begin
        if (fill_table) n_appends = MAX_ENTRIES + 2;
        else if ($urandom_range(0, 7) == 0) n_appends = $urandom_range(20, MAX_ENTRIES + 2);
        else n_appends = $urandom_range(1, 10);
        fill_table = 1'b0;
        if ($urandom_range(0, 7) != 0) push_cmd(random_word(ACT_BEGIN), 1'b0, r);
        for (int k = 0; k < n_appends; k++) begin
          w = random_word(ACT_APPEND);
          w.elem_w = random_size();
          w.elem_h = random_size();
          if ($urandom_range(0, 3) != 0) w.elem_type = 8'($urandom_range(0, 63));
          // A small pool of ids lets a new map keep the focused id now and then.
          if ($urandom_range(0, 1) != 0) w.elem_id = 16'($urandom_range(0, 7));
          push_cmd(w, 1'b0, r);
        end
        if ($urandom_range(0, 7) != 0) push_cmd(random_word(ACT_END), 1'b0, r);
        n_uses = $urandom_range(4, 16);
        for (int k = 0; k < n_uses; k++) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: begin
              w = random_word(ACT_QUERY);
              pick_point(w.pos_x, w.pos_y);
              if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1) != 0) w.pos_x = FORCE_ARROW;
                else w.pos_y = FORCE_ARROW;
              end
            end
            9, 10, 11, 12, 13, 14, 15: begin
              w = random_word(ACT_CLICK);
              pick_point(w.pos_x, w.pos_y);
            end
            16:      w = random_word(ACT_DEACT);
            17:      w = random_word(ACT_END);
            18:      w = random_word($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO);
            default: w = random_word(3'($urandom_range(0, 7)));
          endcase
          push_cmd(w, 1'b0, r);
        end
      end
    end

    // Wait for the last results, then a little longer for anything stray.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d result words over %0d mask settings; every phase overfilled the table.",
             words_checked, settings_used);
    $display("Seen: %0d hits, %0d click events, %0d cursor changes; %0d mismatches.",
             hits_seen, clicks_seen, shape_changes, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_rectangle_hit_test_focus_map OK");
    end else begin
      $display("tb_rectangle_hit_test_focus_map NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rhtfm_pkg.sv
rtl/rhtfm_if.sv
rtl/rhtfm_ram.sv
rtl/rectangle_hit_test_focus_map.sv
tb/tb_rectangle_hit_test_focus_map.sv
